// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared shorthand for the concurrent checks in the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked only out of reset
`define UHC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("uhc assertion failed");

// next-cycle implication that also holds across reset
`define UHC_ASSERT_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("uhc assertion failed");

`endif

// ===== hw/rtl/uhc_pkg.sv =====
// ----------------------------------------------------------------------------
// uhc_pkg
// types, constants and checksum helpers for the ipv4/udp header checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package uhc_pkg;

  localparam int COUNT_W    = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;

  localparam logic [15:0] CSUM_GOOD        = 16'hFFFF;
  localparam logic [15:0] CLIENT_PORT_RST  = 16'd68;
  localparam logic        UDP_CHECK_EN_RST = 1'b1;

  // byte offsets and minimum lengths
  localparam logic [COUNT_W-1:0] MIN_IP_LEN    = 17'd20;
  localparam logic [COUNT_W-1:0] UDP_HDR_LEN   = 17'd8;
  localparam logic [COUNT_W-1:0] PROTO_OFS     = 17'd9;
  localparam logic [COUNT_W-1:0] PH_ADDR_FIRST = 17'd13;
  localparam logic [COUNT_W-1:0] PH_ADDR_LAST  = 17'd19;
  localparam logic [3:0]         MIN_IHL       = 4'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UDP_CHECK_ENABLE = 1'b0,
    CFG_CLIENT_PORT      = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    STATUS_OK        = 4'd0,
    STATUS_SHORT_IP  = 4'd1,
    STATUS_BAD_IHL   = 4'd2,
    STATUS_SHORT_HDR = 4'd3,
    STATUS_IP_CSUM   = 4'd4,
    STATUS_SHORT_UDP = 4'd5,
    STATUS_SHORT_LEN = 4'd6,
    STATUS_UDP_CSUM  = 4'd7,
    STATUS_PORT      = 4'd8
  } status_t;

  // per-packet totals captured at the final byte
  typedef struct packed {
    logic [COUNT_W-1:0] byte_count;
    logic [3:0]         header_words;
    logic [15:0]        ip_sum;
    logic [15:0]        udp_sum;
    logic [15:0]        udp_length;
    logic [15:0]        src_port;
    logic [15:0]        dest_port;
    logic [15:0]        udp_check_field;
  } snap_t;

  // 16-bit ones' complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0];
  endfunction

  // part of udp header word k that lies inside a segment of length len
  function automatic logic [15:0] hdr_part(input logic [15:0] word, input logic [1:0] k,
                                           input logic [15:0] len);
    logic [16:0] full;
    logic [16:0] half;
    full = {14'd0, k, 1'b0} + 17'd2;
    half = {14'd0, k, 1'b0} + 17'd1;
    if ({1'b0, len} >= full) begin
      return word;
    end else if ({1'b0, len} == half) begin
      return word & 16'hFF00;
    end else begin
      return 16'd0;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ipv4_udp_header_checker_top.sv =====
// ----------------------------------------------------------------------------
// ipv4_udp_header_checker_top
// byte-serial ipv4 header and udp checksum / port checker
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle, starting at the first ipv4 header byte,
// with in_last_byte marking the final byte. Sustained rate is one byte per
// clock unless a status is held; the per-byte sum update sits between the
// input register and the running-state registers. The status word for a
// packet appears on out_valid once its final byte has passed, in turn, the
// input register, packet totals, check stage and output register. While a
// status waits under out_stall the whole pipeline holds and in_stall is
// raised. Configuration writes take effect for packets finished after the
// write.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_udp_header_checker_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [7:0]                        in_data_byte,
  input  wire logic                              in_last_byte,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [3:0]                             out_status,
  input  wire logic                              cfg_wr_en,
  input  wire logic [uhc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [uhc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import uhc_pkg::*;

  logic          pipe_en;
  logic          snap_vld;
  snap_t         snap;
  logic          udp_check_enable_r;
  logic [15:0]   client_port_r;

  // pipeline moves unless a finished status is held off
  assign pipe_en  = !(out_valid && out_stall);
  assign in_stall = !pipe_en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      udp_check_enable_r <= UDP_CHECK_EN_RST;
      client_port_r      <= CLIENT_PORT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_UDP_CHECK_ENABLE: udp_check_enable_r <= cfg_wdata[0];
        CFG_CLIENT_PORT:      client_port_r      <= cfg_wdata[15:0];
        default:              ;
      endcase
    end
  end

  uhc_accum u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .pipe_en      (pipe_en),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .snap_vld     (snap_vld),
    .snap         (snap)
  );

  uhc_eval u_eval (
    .clk              (clk),
    .rst_n            (rst_n),
    .pipe_en          (pipe_en),
    .snap_vld         (snap_vld),
    .snap             (snap),
    .udp_check_enable (udp_check_enable_r),
    .client_port      (client_port_r),
    .out_valid        (out_valid),
    .out_status       (out_status)
  );

  // checks
`include "assert_macros.svh"

  `UHC_ASSERT_IMP(a_stall_only_on_held_word, clk, rst_n, in_stall, out_valid && out_stall)
  `UHC_ASSERT_NEXT(a_no_word_after_reset, clk, !rst_n, !out_valid)
  `UHC_ASSERT_IMP(a_status_in_range, clk, rst_n, out_valid, out_status <= STATUS_PORT)

endmodule

`default_nettype wire

// ===== hw/rtl/uhc_accum.sv =====
// ----------------------------------------------------------------------------
// uhc_accum
// input byte register and per-byte running sums, count and header fields
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uhc_accum (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  pipe_en,
  input  wire logic                  in_valid,
  input  wire logic [7:0]            in_data_byte,
  input  wire logic                  in_last_byte,
  output logic                       snap_vld,
  output uhc_pkg::snap_t             snap
);

  import uhc_pkg::*;

  logic                 in_vld_r;
  logic [7:0]           in_data_r;
  logic                 in_last_r;

  logic [COUNT_W-1:0]   byte_count_r,      byte_count_nxt;
  logic [3:0]           header_words_r,    header_words_nxt;
  logic [15:0]          ip_sum_r,          ip_sum_nxt;
  logic [15:0]          udp_sum_r,         udp_sum_nxt;
  logic [15:0]          udp_length_r,      udp_length_nxt;
  logic [15:0]          udp_check_field_r, udp_check_field_nxt;
  logic [15:0]          dest_port_r,       dest_port_nxt;
  logic [15:0]          src_port_r,        src_port_nxt;
  logic [7:0]           pending_r,         pending_nxt;

  logic                 snap_vld_r;
  snap_t                snap_r;

  logic [COUNT_W-1:0]   n;
  logic [COUNT_W-1:0]   hdrlen;
  logic [COUNT_W-1:0]   seg;
  logic [15:0]          word;
  logic                 odd;
  logic                 in_seg;
  logic [15:0]          ph_add;
  logic [15:0]          seg_add;
  logic                 step;

  assign step = pipe_en & in_vld_r;

  // input byte register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (pipe_en) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en && in_valid) begin
      in_data_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
  end

  // per-byte update of counts, fields and sums
  always_comb begin
    n      = byte_count_r;
    odd    = n[0];
    word   = {pending_r, in_data_r};

    header_words_nxt = (n == '0) ? in_data_r[3:0] : header_words_r;
    hdrlen           = {11'd0, header_words_nxt, 2'b00};

    ip_sum_nxt = (odd && (n < hdrlen)) ? oc_add(ip_sum_r, word) : ip_sum_r;

    // pseudo-header: protocol byte and addresses
    ph_add = 16'd0;
    if (n == PROTO_OFS) begin
      ph_add = {8'h00, in_data_r};
    end else if (odd && (n >= PH_ADDR_FIRST) && (n <= PH_ADDR_LAST)) begin
      ph_add = word;
    end

    // udp header fields and segment payload
    in_seg              = (n >= hdrlen);
    seg                 = n - hdrlen;
    seg_add             = 16'd0;
    src_port_nxt        = src_port_r;
    dest_port_nxt       = dest_port_r;
    udp_length_nxt      = udp_length_r;
    udp_check_field_nxt = udp_check_field_r;
    if (in_seg && (seg < UDP_HDR_LEN)) begin
      if (odd) begin
        unique case (seg[2:1])
          2'd0:    src_port_nxt        = word;
          2'd1:    dest_port_nxt       = word;
          2'd2:    udp_length_nxt      = word;
          default: udp_check_field_nxt = word;
        endcase
      end
    end else if (in_seg && (seg < {1'b0, udp_length_r})) begin
      if (odd) begin
        seg_add = word;
      end else if ((seg + 17'd1) == {1'b0, udp_length_r}) begin
        seg_add = {in_data_r, 8'h00};
      end
    end

    udp_sum_nxt    = oc_add(oc_add(udp_sum_r, ph_add), seg_add);
    pending_nxt    = odd ? pending_r : in_data_r;
    byte_count_nxt = (n != COUNT_MAX) ? n + 17'd1 : COUNT_MAX;
  end

  // running state, cleared after every final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (step && in_last_r)) begin
      byte_count_r      <= '0;
      header_words_r    <= '0;
      ip_sum_r          <= '0;
      udp_sum_r         <= '0;
      udp_length_r      <= '0;
      udp_check_field_r <= '0;
      dest_port_r       <= '0;
      src_port_r        <= '0;
      pending_r         <= '0;
    end else if (step) begin
      byte_count_r      <= byte_count_nxt;
      header_words_r    <= header_words_nxt;
      ip_sum_r          <= ip_sum_nxt;
      udp_sum_r         <= udp_sum_nxt;
      udp_length_r      <= udp_length_nxt;
      udp_check_field_r <= udp_check_field_nxt;
      dest_port_r       <= dest_port_nxt;
      src_port_r        <= src_port_nxt;
      pending_r         <= pending_nxt;
    end
  end

  // packet totals captured on the final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_vld_r <= 1'b0;
    end else if (pipe_en) begin
      snap_vld_r <= in_vld_r & in_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last_r) begin
      snap_r.byte_count      <= byte_count_nxt;
      snap_r.header_words    <= header_words_nxt;
      snap_r.ip_sum          <= ip_sum_nxt;
      snap_r.udp_sum         <= udp_sum_nxt;
      snap_r.udp_length      <= udp_length_nxt;
      snap_r.src_port        <= src_port_nxt;
      snap_r.dest_port       <= dest_port_nxt;
      snap_r.udp_check_field <= udp_check_field_nxt;
    end
  end

  assign snap_vld = snap_vld_r;
  assign snap     = snap_r;

endmodule

`default_nettype wire

// ===== hw/rtl/uhc_eval.sv =====
// ----------------------------------------------------------------------------
// uhc_eval
// length and checksum checks on the packet totals, status output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uhc_eval (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  pipe_en,
  input  wire logic                  snap_vld,
  input  wire uhc_pkg::snap_t        snap,
  input  wire logic                  udp_check_enable,
  input  wire logic [15:0]           client_port,
  output logic                       out_valid,
  output logic [3:0]                 out_status
);

  import uhc_pkg::*;

  // stage one: compares and partial sums
  logic          chk_vld_r;
  logic          short_ip_r;
  logic          bad_ihl_r;
  logic          short_hdr_r;
  logic          ip_csum_bad_r;
  logic          short_udp_r;
  logic          short_len_r;
  logic          udp_chk_on_r;
  logic          port_bad_r;
  logic [15:0]   part_a_r;
  logic [15:0]   part_b_r;

  logic [COUNT_W-1:0] hdrlen;
  logic [COUNT_W-1:0] hdr_udp_end;

  // stage two: output register
  logic          out_vld_r;
  status_t       status_r;
  status_t       status_nxt;
  logic [15:0]   udp_total;

  assign hdrlen      = {11'd0, snap.header_words, 2'b00};
  assign hdr_udp_end = hdrlen + {1'b0, snap.udp_length};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r <= 1'b0;
    end else if (pipe_en) begin
      chk_vld_r <= snap_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en && snap_vld) begin
      short_ip_r    <= snap.byte_count < MIN_IP_LEN;
      bad_ihl_r     <= snap.header_words < MIN_IHL;
      short_hdr_r   <= snap.byte_count < hdrlen;
      ip_csum_bad_r <= snap.ip_sum != CSUM_GOOD;
      short_udp_r   <= snap.byte_count < (hdrlen + UDP_HDR_LEN);
      short_len_r   <= snap.byte_count < hdr_udp_end;
      udp_chk_on_r  <= udp_check_enable && (snap.udp_check_field != 16'd0);
      port_bad_r    <= snap.dest_port != client_port;
      part_a_r      <= oc_add(oc_add(snap.udp_sum, snap.udp_length),
                              hdr_part(snap.src_port, 2'd0, snap.udp_length));
      part_b_r      <= oc_add(oc_add(hdr_part(snap.dest_port, 2'd1, snap.udp_length),
                                     hdr_part(snap.udp_length, 2'd2, snap.udp_length)),
                              hdr_part(snap.udp_check_field, 2'd3, snap.udp_length));
    end
  end

  // first failing check wins
  always_comb begin
    udp_total = oc_add(part_a_r, part_b_r);
    priority if (short_ip_r) begin
      status_nxt = STATUS_SHORT_IP;
    end else if (bad_ihl_r) begin
      status_nxt = STATUS_BAD_IHL;
    end else if (short_hdr_r) begin
      status_nxt = STATUS_SHORT_HDR;
    end else if (ip_csum_bad_r) begin
      status_nxt = STATUS_IP_CSUM;
    end else if (short_udp_r) begin
      status_nxt = STATUS_SHORT_UDP;
    end else if (short_len_r) begin
      status_nxt = STATUS_SHORT_LEN;
    end else if (udp_chk_on_r && (udp_total != CSUM_GOOD)) begin
      status_nxt = STATUS_UDP_CSUM;
    end else if (port_bad_r) begin
      status_nxt = STATUS_PORT;
    end else begin
      status_nxt = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (pipe_en) begin
      out_vld_r <= chk_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en && chk_vld_r) begin
      status_r <= status_nxt;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_status = status_r;

endmodule

`default_nettype wire
